[rtl/cps_pkg.sv]
// Shared types and constants of the Chaikin polyline smoother.
package cps_pkg;

    localparam int RATIO_W     = 15;
    localparam int PASS_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int ROUND_SHIFT = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CUT_RATIO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LOOP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT  = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_MIN   = 15'd3277;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 15'd29491;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 15'd16384;
    localparam logic [PASS_W-1:0]  PASS_RESET  = 3'd1;

    // Emission slots of one cell job, in output order
    localparam int SLOT_N  = 5;
    localparam int SLOT_P0 = 0;
    localparam int SLOT_P1 = 1;
    localparam int SLOT_V  = 2;
    localparam int SLOT_Q0 = 3;
    localparam int SLOT_Q1 = 4;

    typedef logic [SLOT_N-1:0] t_mask;

    // Side info that travels with every point along the chain
    typedef struct packed {
        logic               last;
        logic               err;
        logic [RATIO_W-1:0] ratio;
        logic               closed;
        logic [PASS_W-1:0]  passes;
    } t_ctl;

    typedef enum logic [2:0] {
        F_EMPTY,
        F_ONE,
        F_TWO,
        F_SEND1,
        F_SEND2,
        F_STREAM
    } t_fstate;

endpackage

[rtl/cps_front.sv]
// Front gate: holds the first two vertices of a run, rejects short runs, samples run settings.
module cps_front #(
    parameter int COORD_BITS = 32,
    parameter int MAX_PASSES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0][COORD_BITS-1:0]          i_pt,
    input  logic                                i_eol,
    input  logic [cps_pkg::RATIO_W-1:0]         i_cut_ratio,
    input  logic                                i_closed,
    input  logic [cps_pkg::PASS_W-1:0]          i_passes,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [2:0][COORD_BITS-1:0]          o_pt,
    output cps_pkg::t_ctl                       o_ctl
);

    cps_pkg::t_fstate r_state, n_state;
    logic             r_ov, n_ov;
    logic [2:0][COORD_BITS-1:0] r_opt, n_opt;
    cps_pkg::t_ctl    r_octl, n_octl;
    logic [2:0][COORD_BITS-1:0] r_first, r_second, r_hold;
    logic             r_hold_eol;
    cps_pkg::t_ctl    r_run;
    cps_pkg::t_ctl    w_samp, w_run;
    logic             w_out_free, w_ready, w_accept, w_ld;
    logic             w_st_first, w_st_second, w_st_hold;

    assign w_out_free = !r_ov || i_ready;
    assign w_accept   = i_valid && w_ready;
    assign o_ready    = w_ready;
    assign o_valid    = r_ov;
    assign o_pt       = r_opt;
    assign o_ctl      = r_octl;

    // Clamp settings at the first vertex of a run
    always_comb begin
        w_samp        = '0;
        w_samp.closed = i_closed;
        if (i_cut_ratio < cps_pkg::RATIO_MIN) begin
            w_samp.ratio = cps_pkg::RATIO_MIN;
        end else if (i_cut_ratio > cps_pkg::RATIO_MAX) begin
            w_samp.ratio = cps_pkg::RATIO_MAX;
        end else begin
            w_samp.ratio = i_cut_ratio;
        end
        if (i_passes == '0) begin
            w_samp.passes = cps_pkg::PASS_W'(1);
        end else if (i_passes > cps_pkg::PASS_W'(MAX_PASSES)) begin
            w_samp.passes = cps_pkg::PASS_W'(MAX_PASSES);
        end else begin
            w_samp.passes = i_passes;
        end
        w_run = (r_state == cps_pkg::F_EMPTY) ? w_samp : r_run;
    end

    always_comb begin
        n_state     = r_state;
        n_opt       = r_opt;
        n_octl      = r_octl;
        w_ld        = 1'b0;
        w_ready     = 1'b0;
        w_st_first  = 1'b0;
        w_st_second = 1'b0;
        w_st_hold   = 1'b0;
        case (r_state)
            cps_pkg::F_EMPTY, cps_pkg::F_ONE: begin
                w_ready = w_out_free;
                if (i_valid && w_out_free) begin
                    if (i_eol) begin
                        // short run: one error beat
                        w_ld        = 1'b1;
                        n_opt       = '0;
                        n_octl      = w_run;
                        n_octl.err  = 1'b1;
                        n_octl.last = 1'b1;
                        n_state     = cps_pkg::F_EMPTY;
                    end else if (r_state == cps_pkg::F_EMPTY) begin
                        w_st_first = 1'b1;
                        n_state    = cps_pkg::F_ONE;
                    end else begin
                        w_st_second = 1'b1;
                        n_state     = cps_pkg::F_TWO;
                    end
                end
            end
            cps_pkg::F_TWO: begin
                w_ready = w_out_free;
                if (i_valid && w_out_free) begin
                    w_ld      = 1'b1;
                    w_st_hold = 1'b1;
                    n_opt     = r_first;
                    n_octl    = w_run;
                    n_state   = cps_pkg::F_SEND1;
                end
            end
            cps_pkg::F_SEND1: begin
                if (w_out_free) begin
                    w_ld    = 1'b1;
                    n_opt   = r_second;
                    n_octl  = r_run;
                    n_state = cps_pkg::F_SEND2;
                end
            end
            cps_pkg::F_SEND2: begin
                if (w_out_free) begin
                    w_ld        = 1'b1;
                    n_opt       = r_hold;
                    n_octl      = r_run;
                    n_octl.last = r_hold_eol;
                    n_state     = r_hold_eol ? cps_pkg::F_EMPTY : cps_pkg::F_STREAM;
                end
            end
            cps_pkg::F_STREAM: begin
                w_ready = w_out_free;
                if (i_valid && w_out_free) begin
                    w_ld        = 1'b1;
                    n_opt       = i_pt;
                    n_octl      = r_run;
                    n_octl.last = i_eol;
                    n_state     = i_eol ? cps_pkg::F_EMPTY : cps_pkg::F_STREAM;
                end
            end
            default: begin
                n_state = cps_pkg::F_EMPTY;
            end
        endcase
        if (w_ld) begin
            n_ov = 1'b1;
        end else if (i_ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cps_pkg::F_EMPTY;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opt  <= n_opt;
        r_octl <= n_octl;
        if (w_accept && r_state == cps_pkg::F_EMPTY) begin
            r_run <= w_samp;
        end
        if (w_st_first) begin
            r_first <= i_pt;
        end
        if (w_st_second) begin
            r_second <= i_pt;
        end
        if (w_st_hold) begin
            r_hold     <= i_pt;
            r_hold_eol <= i_eol;
        end
    end

    a_third_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_state == cps_pkg::F_TWO)
        |=> (r_ov && !r_octl.last && r_state == cps_pkg::F_SEND1))
        else $error("third vertex did not release the held vertices");

    a_err_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_octl.err) |-> (r_octl.last && r_opt == '0))
        else $error("error beat without last flag or with nonzero point");

endmodule

[rtl/cps_cell.sv]
// One smoothing pass: cuts segments of its stream; if inactive, forwards it.
module cps_cell #(
    parameter int COORD_BITS = 32,
    parameter int STAGE      = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0][COORD_BITS-1:0]   i_pt,
    input  cps_pkg::t_ctl                i_ctl,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2:0][COORD_BITS-1:0]   o_pt,
    output cps_pkg::t_ctl                o_ctl
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + cps_pkg::RATIO_W + 2;
    localparam logic [PW-1:0] HALF = PW'(1) << (cps_pkg::ROUND_SHIFT - 1);

    // per-run state of this pass
    logic [2:0][COORD_BITS-1:0] r_first, r_prev;
    logic [1:0]                 r_cnt;

    // difference stage
    logic                       r1_valid;
    logic [2:0][COORD_BITS-1:0] r1_v, r1_prev, r1_first;
    logic [2:0][DW-1:0]         r1_d1, r1_d2;
    cps_pkg::t_mask             r1_mask;
    cps_pkg::t_ctl              r1_ctl;

    // product stage, holds the job while its points go out
    logic                       r2_valid;
    logic [2:0][COORD_BITS-1:0] r2_v, r2_prev, r2_first;
    logic [2:0][PW-1:0]         r2_m1, r2_m2;
    cps_pkg::t_mask             r2_mask;
    cps_pkg::t_ctl              r2_ctl;

    // output register
    logic                       r_d_valid;
    logic [2:0][COORD_BITS-1:0] r_d_pt;
    cps_pkg::t_ctl              r_d_ctl;

    logic                       w_active, w_accept;
    logic [2:0][COORD_BITS-1:0] w_first_eff;
    logic [2:0][DW-1:0]         w_d1, w_d2;
    logic [2:0][PW-1:0]         w_m1, w_m2;
    cps_pkg::t_mask             w_mask, w_next_mask;
    logic                       w_single, w_d_load, w_r2_done, w_r2_free, w_r1_move;
    logic [2:0][COORD_BITS-1:0] e_base, e_pt;
    logic [2:0][PW-1:0]         e_prod, e_term, e_rnd;
    logic                       e_use1, e_use2, e_neg;
    cps_pkg::t_ctl              w_d_ctl;

    assign w_active = !i_ctl.err && (cps_pkg::PASS_W'(STAGE) < i_ctl.passes);

    assign w_next_mask = r2_mask & (r2_mask - 1'b1);
    assign w_single    = (w_next_mask == '0);
    assign w_d_load    = r2_valid && (!r_d_valid || i_ready);
    assign w_r2_done   = w_d_load && w_single;
    assign w_r2_free   = !r2_valid || w_r2_done;
    assign w_r1_move   = r1_valid && w_r2_free;
    assign o_ready     = !r1_valid || w_r2_free;
    assign w_accept    = i_valid && o_ready;

    assign o_valid = r_d_valid;
    assign o_pt    = r_d_pt;
    assign o_ctl   = r_d_ctl;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_first_eff[k] = (r_cnt == 2'd0) ? i_pt[k] : r_first[k];
            w_d1[k] = {i_pt[k][COORD_BITS-1], i_pt[k]}
                    - {r_prev[k][COORD_BITS-1], r_prev[k]};
            w_d2[k] = {w_first_eff[k][COORD_BITS-1], w_first_eff[k]}
                    - {i_pt[k][COORD_BITS-1], i_pt[k]};
        end
    end

    // signed products at full width
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_m1[k] = $signed(r1_d1[k]) * $signed({1'b0, r1_ctl.ratio});
            w_m2[k] = $signed(r1_d2[k]) * $signed({1'b0, r1_ctl.ratio});
        end
    end

    // which points this vertex produces
    always_comb begin
        w_mask = '0;
        if (!w_active) begin
            w_mask[cps_pkg::SLOT_V] = 1'b1;
        end else if (i_ctl.closed) begin
            if (r_cnt != 2'd0) begin
                w_mask[cps_pkg::SLOT_P0] = 1'b1;
                w_mask[cps_pkg::SLOT_P1] = 1'b1;
            end
            if (i_ctl.last) begin
                w_mask[cps_pkg::SLOT_Q0] = 1'b1;
                w_mask[cps_pkg::SLOT_Q1] = 1'b1;
            end
        end else if (r_cnt == 2'd0) begin
            w_mask[cps_pkg::SLOT_V] = 1'b1;
        end else begin
            // drop the outer cut of the first segment
            if (r_cnt != 2'd1) begin
                w_mask[cps_pkg::SLOT_P0] = 1'b1;
            end
            if (i_ctl.last) begin
                w_mask[cps_pkg::SLOT_V] = 1'b1;
            end else begin
                w_mask[cps_pkg::SLOT_P1] = 1'b1;
            end
        end
    end

    // pick the lowest pending slot and round its cut point
    always_comb begin
        e_base = r2_v;
        e_use1 = 1'b0;
        e_use2 = 1'b0;
        e_neg  = 1'b0;
        if (r2_mask[cps_pkg::SLOT_P0]) begin
            e_base = r2_prev;
            e_use1 = 1'b1;
        end else if (r2_mask[cps_pkg::SLOT_P1]) begin
            e_use1 = 1'b1;
            e_neg  = 1'b1;
        end else if (r2_mask[cps_pkg::SLOT_V]) begin
            e_base = r2_v;
        end else if (r2_mask[cps_pkg::SLOT_Q0]) begin
            e_use2 = 1'b1;
        end else begin
            e_base = r2_first;
            e_use2 = 1'b1;
            e_neg  = 1'b1;
        end
        for (int k = 0; k < 3; k++) begin
            e_prod[k] = e_use1 ? r2_m1[k] : (e_use2 ? r2_m2[k] : '0);
            e_term[k] = e_neg ? (~e_prod[k] + 1'b1) : e_prod[k];
            e_rnd[k]  = e_term[k] + HALF;
            e_pt[k]   = e_base[k] + e_rnd[k][cps_pkg::ROUND_SHIFT +: COORD_BITS];
        end
        w_d_ctl      = r2_ctl;
        w_d_ctl.last = r2_ctl.last && w_single;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 2'd0;
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_accept && w_active) begin
                if (i_ctl.last) begin
                    r_cnt <= 2'd0;
                end else if (r_cnt != 2'd2) begin
                    r_cnt <= r_cnt + 2'd1;
                end
            end
            if (w_accept) begin
                r1_valid <= 1'b1;
            end else if (w_r1_move) begin
                r1_valid <= 1'b0;
            end
            if (w_r1_move) begin
                // a job with no points is dropped here
                r2_valid <= (r1_mask != '0);
            end else if (w_r2_done) begin
                r2_valid <= 1'b0;
            end
            if (w_d_load) begin
                r_d_valid <= 1'b1;
            end else if (i_ready) begin
                r_d_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_active) begin
            r_prev <= i_pt;
            if (r_cnt == 2'd0) begin
                r_first <= i_pt;
            end
        end
        if (w_accept) begin
            r1_v     <= i_pt;
            r1_prev  <= r_prev;
            r1_first <= w_first_eff;
            r1_d1    <= w_d1;
            r1_d2    <= w_d2;
            r1_mask  <= w_mask;
            r1_ctl   <= i_ctl;
        end
        if (w_r1_move) begin
            r2_v     <= r1_v;
            r2_prev  <= r1_prev;
            r2_first <= r1_first;
            r2_mask  <= r1_mask;
            r2_ctl   <= r1_ctl;
            r2_m1    <= w_m1;
            r2_m2    <= w_m2;
        end else if (w_d_load) begin
            r2_mask <= w_next_mask;
        end
        if (w_d_load) begin
            r_d_pt  <= e_pt;
            r_d_ctl <= w_d_ctl;
        end
    end

    a_job_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid |-> (r2_mask != '0))
        else $error("held job has no pending points");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("vertex count passed its saturation value");

    a_err_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && r_d_ctl.err) |-> r_d_ctl.last)
        else $error("error beat lost its last flag in the pass");

endmodule

[rtl/chaikin_polyline_smoothing.sv]
// Top level of the Chaikin polyline smoother: config registers, front gate, chain of passes.
//
// Vertices enter as beats on the slave stream, tlast marking the end of a polyline; smoothed
// points leave on the master stream, tlast on the final point and tuser set on the single
// all-zero beat that rejects a polyline of fewer than three vertices. Settings are sampled at
// the first vertex of each polyline, so writes take effect on the next one. Each pass is a
// cell of the chain that emits at most one point per cycle from its output register; the last
// active pass sets the rate. The third vertex of a line also sends the two held vertices
// down the chain. The closing vertex of a closed line adds the wrap-segment points. Each point
// passes the front's output register and, in each of the MAX_PASSES cells, active or not, the
// difference, product and output registers.
module chaikin_polyline_smoothing #(
    parameter int COORD_BITS = 32,
    parameter int MAX_PASSES = 4,
    localparam int DATA_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [DATA_W-1:0]                s_axis_tdata,   // vx, vy, vz
    input  logic                             s_axis_tlast,   // end_of_line
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [DATA_W-1:0]                m_axis_tdata,   // ox, oy, oz
    output logic                             m_axis_tlast,   // final_point
    output logic                             m_axis_tuser,   // too_short
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [cps_pkg::RATIO_W-1:0] r_cut_ratio;
    logic                        r_closed_loop;
    logic [cps_pkg::PASS_W-1:0]  r_pass_count;

    logic [MAX_PASSES:0]         ch_valid, ch_ready;
    logic [2:0][COORD_BITS-1:0]  ch_pt  [MAX_PASSES+1];
    cps_pkg::t_ctl               ch_ctl [MAX_PASSES+1];
    logic [2:0][COORD_BITS-1:0]  w_in_pt;

    assign o_cfg_ready = 1'b1;
    assign w_in_pt     = s_axis_tdata[3*COORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_ratio   <= cps_pkg::RATIO_RESET;
            r_closed_loop <= 1'b0;
            r_pass_count  <= cps_pkg::PASS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cps_pkg::CFG_CUT_RATIO:   r_cut_ratio   <= i_cfg_data[cps_pkg::RATIO_W-1:0];
                cps_pkg::CFG_CLOSED_LOOP: r_closed_loop <= i_cfg_data[0];
                cps_pkg::CFG_PASS_COUNT:  r_pass_count  <= i_cfg_data[cps_pkg::PASS_W-1:0];
                default: begin
                    // unmapped index: drop the beat
                end
            endcase
        end
    end

    cps_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_PASSES (MAX_PASSES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pt        (w_in_pt),
        .i_eol       (s_axis_tlast),
        .i_cut_ratio (r_cut_ratio),
        .i_closed    (r_closed_loop),
        .i_passes    (r_pass_count),
        .o_valid     (ch_valid[0]),
        .i_ready     (ch_ready[0]),
        .o_pt        (ch_pt[0]),
        .o_ctl       (ch_ctl[0])
    );

    for (genvar g = 0; g < MAX_PASSES; g++) begin : g_pass
        cps_cell #(
            .COORD_BITS (COORD_BITS),
            .STAGE      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (ch_valid[g]),
            .o_ready (ch_ready[g]),
            .i_pt    (ch_pt[g]),
            .i_ctl   (ch_ctl[g]),
            .o_valid (ch_valid[g+1]),
            .i_ready (ch_ready[g+1]),
            .o_pt    (ch_pt[g+1]),
            .o_ctl   (ch_ctl[g+1])
        );
    end

    assign m_axis_tvalid         = ch_valid[MAX_PASSES];
    assign ch_ready[MAX_PASSES]  = m_axis_tready;
    assign m_axis_tdata          = DATA_W'(ch_pt[MAX_PASSES]);
    assign m_axis_tlast          = ch_ctl[MAX_PASSES].last;
    assign m_axis_tuser          = ch_ctl[MAX_PASSES].err;

endmodule
